// ===== hdl/gsp_pkg.sv =====
// shared types, constants and command tables for the gamepad serial poller
package gsp_pkg;

    localparam int PACKET_BYTES = 9;
    localparam int CFG_PACKET_BYTES = 9;
    localparam int ENTER_BYTES = 5;
    localparam int IDX_W =
        $clog2(((PACKET_BYTES > CFG_PACKET_BYTES) ? PACKET_BYTES : CFG_PACKET_BYTES) + 1);

    localparam logic [2:0] PH_INIT_POLL  = 3'd0;
    localparam logic [2:0] PH_ENTER      = 3'd1;
    localparam logic [2:0] PH_LOCK       = 3'd2;
    localparam logic [2:0] PH_EXIT       = 3'd3;
    localparam logic [2:0] PH_CHECK_POLL = 3'd4;
    localparam logic [2:0] PH_IDLE       = 3'd5;
    localparam logic [2:0] PH_PERIODIC   = 3'd6;

    localparam int ID_BYTE    = 1;
    localparam int KEY_LO     = 3;
    localparam int KEY_HI     = 4;
    localparam int STICK_BASE = 5;

    localparam logic [7:0]  ID_ANALOG     = 8'h73;
    localparam logic [7:0]  ID_MASK       = 8'hF0;
    localparam logic [7:0]  ID_LOCKED     = 8'h70;
    localparam logic [7:0]  STICK_CENTER  = 8'd128;
    localparam logic [7:0]  STORE_RESET   = 8'hFF;
    localparam logic [15:0] INTERVAL_RST  = 16'd2000;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } gsp_store_wr_t;

    typedef struct packed {
        logic select_n;
        logic clock_pin;
        logic command_pin;
        logic analog_locked;
        logic poll_done;
    } gsp_pins_t;

    function automatic logic is_poll(input logic [2:0] ph);
        is_poll = (ph == PH_INIT_POLL) || (ph == PH_CHECK_POLL) || (ph == PH_PERIODIC);
    endfunction

    function automatic logic [IDX_W-1:0] packet_len(input logic [2:0] ph);
        case (ph)
            PH_ENTER:         packet_len = IDX_W'(ENTER_BYTES);
            PH_LOCK, PH_EXIT: packet_len = IDX_W'(CFG_PACKET_BYTES);
            default:          packet_len = IDX_W'(PACKET_BYTES);
        endcase
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [2:0] ph, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (ph)
            PH_ENTER:
            begin
                case (idx)
                    IDX_W'(0): b = 8'h01;
                    IDX_W'(1): b = 8'h43;
                    IDX_W'(3): b = 8'h01;
                    default:   b = 8'h00;
                endcase
            end
            PH_LOCK:
            begin
                case (idx)
                    IDX_W'(0): b = 8'h01;
                    IDX_W'(1): b = 8'h44;
                    IDX_W'(3): b = 8'h01;
                    IDX_W'(4): b = 8'h03;
                    default:   b = 8'h00;
                endcase
            end
            PH_EXIT:
            begin
                case (idx)
                    IDX_W'(0): b = 8'h01;
                    IDX_W'(1): b = 8'h43;
                    IDX_W'(4), IDX_W'(5), IDX_W'(6), IDX_W'(7), IDX_W'(8): b = 8'h5A;
                    default:   b = 8'h00;
                endcase
            end
            default:
            begin
                case (idx)
                    IDX_W'(0): b = 8'h01;
                    IDX_W'(1): b = 8'h42;
                    default:   b = 8'h00;
                endcase
            end
        endcase
        cmd_byte = b;
    endfunction

endpackage

// ===== hdl/gsp_link_fsm.sv =====
// link sequencer: packet phases, bit timing, receive shifter and poll interval
module gsp_link_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   data_pin,
    input  logic [15:0]            poll_interval,
    input  logic [7:0]             store_id,
    output gsp_pkg::gsp_store_wr_t store_wr,
    output gsp_pkg::gsp_pins_t     pins
);

    logic [2:0]              phase_reg, phase_next;
    logic [gsp_pkg::IDX_W-1:0] byte_reg, byte_next;
    logic [2:0]              bit_reg, bit_next;
    logic                    half_reg, half_next;
    logic [7:0]              shift_reg, shift_next;
    logic [15:0]             count_reg, count_next;
    logic                    locked_reg, locked_next;
    logic                    gap_reg, gap_next;

    logic                    idle;
    logic [15:0]             limit;
    logic [15:0]             count_inc;
    logic [7:0]              cmd_cur;
    logic [7:0]              shift_sampled;
    logic [gsp_pkg::IDX_W-1:0] byte_inc;

    assign idle      = (phase_reg == gsp_pkg::PH_IDLE) || (phase_reg > gsp_pkg::PH_PERIODIC);
    assign limit     = (poll_interval != 16'd0) ? poll_interval : 16'd1;
    assign count_inc = count_reg + {15'd0, (count_reg != gsp_pkg::COUNT_MAX)};
    assign cmd_cur   = gsp_pkg::cmd_byte(phase_reg, byte_reg);
    assign byte_inc  = byte_reg + gsp_pkg::IDX_W'(1);

    always_comb
    begin
        shift_sampled = shift_reg;
        shift_sampled[bit_reg] = shift_reg[bit_reg] | data_pin;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        byte_next   = byte_reg;
        bit_next    = bit_reg;
        half_next   = half_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        locked_next = locked_reg;
        gap_next    = gap_reg;
        store_wr    = '0;
        pins.select_n    = 1'b1;
        pins.clock_pin   = 1'b1;
        pins.command_pin = 1'b1;
        pins.poll_done   = 1'b0;

        if (gap_reg)
        begin
            gap_next = 1'b0;
        end
        else if (idle)
        begin
            phase_next = gsp_pkg::PH_IDLE;
            count_next = count_inc;
            if (count_inc >= limit)
            begin
                phase_next = gsp_pkg::PH_PERIODIC;
                count_next = 16'd0;
                byte_next  = '0;
                bit_next   = 3'd0;
                half_next  = 1'b0;
                shift_next = 8'd0;
            end
        end
        else
        begin
            pins.select_n    = 1'b0;
            pins.command_pin = cmd_cur[bit_reg];
            if (!half_reg)
            begin
                pins.clock_pin = 1'b0;
                half_next      = 1'b1;
            end
            else
            begin
                half_next  = 1'b0;
                shift_next = shift_sampled;
                if (bit_reg == 3'd7)
                begin
                    if (gsp_pkg::is_poll(phase_reg) &&
                        (byte_reg < gsp_pkg::IDX_W'(gsp_pkg::PACKET_BYTES)))
                    begin
                        store_wr.wr_en = 1'b1;
                        store_wr.idx   = byte_reg;
                        store_wr.data  = shift_sampled;
                    end
                    shift_next = 8'd0;
                    bit_next   = 3'd0;
                    byte_next  = byte_inc;
                    if (byte_inc >= gsp_pkg::packet_len(phase_reg))
                    begin
                        byte_next = '0;
                        gap_next  = 1'b1;
                        pins.poll_done = gsp_pkg::is_poll(phase_reg);
                        case (phase_reg)
                            gsp_pkg::PH_CHECK_POLL:
                            begin
                                if ((store_id & gsp_pkg::ID_MASK) == gsp_pkg::ID_LOCKED)
                                begin
                                    locked_next = 1'b1;
                                    phase_next  = gsp_pkg::PH_IDLE;
                                    count_next  = 16'd0;
                                end
                                else
                                begin
                                    phase_next = gsp_pkg::PH_ENTER;
                                end
                            end
                            gsp_pkg::PH_PERIODIC:
                            begin
                                phase_next = gsp_pkg::PH_IDLE;
                                count_next = 16'd0;
                            end
                            default:
                            begin
                                phase_next = phase_reg + 3'd1;
                            end
                        endcase
                    end
                end
                else
                begin
                    bit_next = bit_reg + 3'd1;
                end
            end
        end
        pins.analog_locked = locked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= gsp_pkg::PH_INIT_POLL;
            byte_reg   <= '0;
            bit_reg    <= 3'd0;
            half_reg   <= 1'b0;
            shift_reg  <= 8'd0;
            count_reg  <= 16'd0;
            locked_reg <= 1'b0;
            gap_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            byte_reg   <= byte_next;
            bit_reg    <= bit_next;
            half_reg   <= half_next;
            shift_reg  <= shift_next;
            count_reg  <= count_next;
            locked_reg <= locked_next;
            gap_reg    <= gap_next;
        end
    end

`ifndef SYNTH
    // lock is sticky
    a_locked_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |=> locked_reg)
        else $error("analog lock dropped");

    // idle waits only at a byte boundary
    a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == gsp_pkg::PH_IDLE) |-> (bit_reg == 3'd0 && half_reg == 1'b0))
        else $error("idle entered mid byte");

    // first half of a bit is always followed by the second half
    a_half_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !gap_reg && !idle && !half_reg) |=> half_reg)
        else $error("bit half sequence broken");

    // store writes only on the sampling half of the last bit
    a_write_timing: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.wr_en |-> (half_reg && bit_reg == 3'd7 && !pins.select_n))
        else $error("store write outside byte end");
`endif

endmodule

// ===== hdl/gsp_packet_store.sv =====
// received poll bytes with key release and key and stick read out
module gsp_packet_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   key_read,
    input  logic [15:0]            keep_mask,
    input  logic [1:0]             stick_select,
    input  gsp_pkg::gsp_store_wr_t store_wr,
    output logic [7:0]             store_id,
    output logic [15:0]            keys,
    output logic [7:0]             stick_value
);

    logic [7:0] store_reg [gsp_pkg::PACKET_BYTES];
    logic [7:0] store_next [gsp_pkg::PACKET_BYTES];
    logic [15:0] key_word;
    logic [15:0] key_released;
    logic [gsp_pkg::IDX_W-1:0] stick_idx;

    assign key_word     = {store_reg[gsp_pkg::KEY_HI], store_reg[gsp_pkg::KEY_LO]};
    assign key_released = key_word | ~keep_mask;
    assign keys         = ~key_word;
    assign store_id     = store_reg[gsp_pkg::ID_BYTE];
    assign stick_idx    = gsp_pkg::IDX_W'(gsp_pkg::STICK_BASE) + gsp_pkg::IDX_W'(stick_select);

    always_comb
    begin
        stick_value = gsp_pkg::STICK_CENTER;
        if ((store_reg[gsp_pkg::ID_BYTE] == gsp_pkg::ID_ANALOG) &&
            (stick_idx < gsp_pkg::IDX_W'(gsp_pkg::PACKET_BYTES)))
        begin
            stick_value = store_reg[stick_idx];
        end
    end

    // release goes first, a byte landing on the same tick wins
    always_comb
    begin
        for (int i = 0; i < gsp_pkg::PACKET_BYTES; i++)
        begin
            store_next[i] = store_reg[i];
            if (key_read && i == gsp_pkg::KEY_LO)
            begin
                store_next[i] = key_released[7:0];
            end
            if (key_read && i == gsp_pkg::KEY_HI)
            begin
                store_next[i] = key_released[15:8];
            end
            if (store_wr.wr_en && store_wr.idx == gsp_pkg::IDX_W'(i))
            begin
                store_next[i] = store_wr.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gsp_pkg::PACKET_BYTES; i++)
            begin
                store_reg[i] <= gsp_pkg::STORE_RESET;
            end
        end
        else if (step)
        begin
            for (int i = 0; i < gsp_pkg::PACKET_BYTES; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule

// ===== hdl/gamepad_serial_poller.sv =====
// gamepad serial poller top level: input and result registers around the link logic
// dataflow: a tick word is taken into the input registers, then processed into the result
//   register when the result slot is free or draining; out_stall on a full slot holds it
// throughput: one tick word per unstalled cycle, set by the single input-to-result pass
// reset: the link starts with one poll packet, the packet store reads all ones,
//   the poll interval register is 2000 and analog lock is clear
module gamepad_serial_poller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        data_pin,
    input  logic        key_read,
    input  logic [15:0] keep_mask,
    input  logic [1:0]  stick_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        select_n,
    output logic        clock_pin,
    output logic        command_pin,
    output logic [15:0] keys,
    output logic [7:0]  stick_value,
    output logic        analog_locked,
    output logic        poll_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    logic        data_reg;
    logic        key_read_reg;
    logic [15:0] keep_mask_reg;
    logic [1:0]  stick_select_reg;
    logic        out_valid_reg;
    logic [15:0] interval_reg;
    logic        step;

    gsp_pkg::gsp_store_wr_t store_wr;
    gsp_pkg::gsp_pins_t     pins;
    logic [7:0]             store_id;
    logic [15:0]            keys_cur;
    logic [7:0]             stick_cur;

    gsp_pkg::gsp_pins_t     pins_reg;
    logic [15:0]            keys_reg;
    logic [7:0]             stick_reg;

    // a held word moves on whenever the result slot is free or draining
    assign step      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= gsp_pkg::INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            interval_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg         <= data_pin;
            key_read_reg     <= key_read;
            keep_mask_reg    <= keep_mask;
            stick_select_reg <= stick_select;
        end
    end

    gsp_link_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_pin      (data_reg),
        .poll_interval (interval_reg),
        .store_id      (store_id),
        .store_wr      (store_wr),
        .pins          (pins)
    );

    gsp_packet_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .key_read     (key_read_reg),
        .keep_mask    (keep_mask_reg),
        .stick_select (stick_select_reg),
        .store_wr     (store_wr),
        .store_id     (store_id),
        .keys         (keys_cur),
        .stick_value  (stick_cur)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pins_reg  <= pins;
            keys_reg  <= keys_cur;
            stick_reg <= stick_cur;
        end
    end

    assign out_valid     = out_valid_reg;
    assign select_n      = pins_reg.select_n;
    assign clock_pin     = pins_reg.clock_pin;
    assign command_pin   = pins_reg.command_pin;
    assign analog_locked = pins_reg.analog_locked;
    assign poll_done     = pins_reg.poll_done;
    assign keys          = keys_reg;
    assign stick_value   = stick_reg;

endmodule

// ===== sim/gsp_link_checker.sv =====
// checker for the gamepad serial poller: predicts every result word and compares it
module gsp_link_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        data_pin,
    input  logic        key_read,
    input  logic [15:0] keep_mask,
    input  logic [1:0]  stick_select,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        select_n,
    input  logic        clock_pin,
    input  logic        command_pin,
    input  logic [15:0] keys,
    input  logic [7:0]  stick_value,
    input  logic        analog_locked,
    input  logic        poll_done,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic [2:0]  link_phase,
    output int          byte_pos,
    output int          bit_pos,
    output logic        second_half,
    output logic        gap_pending,
    output logic        locked,
    output int          polls_done,
    output int          pending,
    output int          fail_count
);

    // command bytes, byte 0 in the low bits
    localparam logic [39:0] ENTER_SEQ = 40'h00_01_00_43_01;
    localparam logic [71:0] LOCK_SEQ  = 72'h00_00_00_00_03_01_00_44_01;
    localparam logic [71:0] EXIT_SEQ  = 72'h5A_5A_5A_5A_5A_00_00_43_01;
    localparam logic [15:0] POLL_HEAD = 16'h42_01;

    typedef struct packed {
        logic        select_n;
        logic        clock_pin;
        logic        command_pin;
        logic [15:0] keys;
        logic [7:0]  stick_value;
        logic        analog_locked;
        logic        poll_done;
    } link_result_t;

    link_result_t expected_pins[$];
    link_result_t want;
    link_result_t got;

    logic [7:0]  rx_shift;
    logic [7:0]  pad_store [gsp_pkg::PACKET_BYTES];
    logic [15:0] idle_ticks;
    logic [15:0] poll_interval;

    function automatic logic polling(input logic [2:0] ph);
        return ph == gsp_pkg::PH_INIT_POLL || ph == gsp_pkg::PH_CHECK_POLL ||
               ph == gsp_pkg::PH_PERIODIC;
    endfunction

    function automatic int frame_length(input logic [2:0] ph);
        case (ph)
            gsp_pkg::PH_ENTER:                  return gsp_pkg::ENTER_BYTES;
            gsp_pkg::PH_LOCK, gsp_pkg::PH_EXIT: return gsp_pkg::CFG_PACKET_BYTES;
            default:                            return gsp_pkg::PACKET_BYTES;
        endcase
    endfunction

    function automatic logic [7:0] command_byte(input logic [2:0] ph, input int idx);
        case (ph)
            gsp_pkg::PH_ENTER:
                return (idx < gsp_pkg::ENTER_BYTES) ? ENTER_SEQ[idx*8 +: 8] : 8'h00;
            gsp_pkg::PH_LOCK:  return (idx < 9) ? LOCK_SEQ[idx*8 +: 8] : 8'h00;
            gsp_pkg::PH_EXIT:  return (idx < 9) ? EXIT_SEQ[idx*8 +: 8] : 8'h00;
            default:           return (idx < 2) ? POLL_HEAD[idx*8 +: 8] : 8'h00;
        endcase
    endfunction

    // one half-bit tick of the link
    task automatic step_link(input logic din, input logic kread, input logic [15:0] keep,
                             input logic [1:0] sel, output link_result_t r);
        logic [15:0] word;
        logic [15:0] lim;
        logic [7:0]  cmd_word;
        int          sidx;
        int          b;
        word = {pad_store[gsp_pkg::KEY_HI], pad_store[gsp_pkg::KEY_LO]};
        sidx = gsp_pkg::STICK_BASE + sel;
        r = '0;
        r.select_n = 1'b1;
        r.clock_pin = 1'b1;
        r.command_pin = 1'b1;
        r.keys = ~word;
        r.stick_value = gsp_pkg::STICK_CENTER;
        if (pad_store[gsp_pkg::ID_BYTE] == gsp_pkg::ID_ANALOG && sidx < gsp_pkg::PACKET_BYTES)
            r.stick_value = pad_store[sidx];

        // release comes first, a byte landing on this tick wins
        if (kread)
        begin
            word = word | ~keep;
            pad_store[gsp_pkg::KEY_LO] = word[7:0];
            pad_store[gsp_pkg::KEY_HI] = word[15:8];
        end

        if (gap_pending)
        begin
            gap_pending = 1'b0;
        end
        else if (link_phase == gsp_pkg::PH_IDLE || link_phase > gsp_pkg::PH_PERIODIC)
        begin
            lim = (poll_interval == 16'd0) ? 16'd1 : poll_interval;
            link_phase = gsp_pkg::PH_IDLE;
            if (idle_ticks != gsp_pkg::COUNT_MAX)
                idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks >= lim)
            begin
                link_phase = gsp_pkg::PH_PERIODIC;
                idle_ticks = '0;
                byte_pos = 0;
                bit_pos = 0;
                second_half = 1'b0;
                rx_shift = '0;
            end
        end
        else
        begin
            b = bit_pos;
            cmd_word = command_byte(link_phase, byte_pos);
            r.select_n = 1'b0;
            r.command_pin = cmd_word[b];
            if (!second_half)
            begin
                r.clock_pin = 1'b0;
                second_half = 1'b1;
            end
            else
            begin
                second_half = 1'b0;
                if (din)
                    rx_shift[b] = 1'b1;
                if (b == 7)
                begin
                    if (polling(link_phase) && byte_pos < gsp_pkg::PACKET_BYTES)
                        pad_store[byte_pos] = rx_shift;
                    rx_shift = '0;
                    bit_pos = 0;
                    byte_pos++;
                    if (byte_pos >= frame_length(link_phase))
                    begin
                        byte_pos = 0;
                        gap_pending = 1'b1;
                        if (polling(link_phase))
                        begin
                            r.poll_done = 1'b1;
                            polls_done++;
                        end
                        if (link_phase == gsp_pkg::PH_CHECK_POLL)
                        begin
                            if ((pad_store[gsp_pkg::ID_BYTE] & gsp_pkg::ID_MASK) ==
                                gsp_pkg::ID_LOCKED)
                            begin
                                locked = 1'b1;
                                link_phase = gsp_pkg::PH_IDLE;
                                idle_ticks = '0;
                            end
                            else
                            begin
                                link_phase = gsp_pkg::PH_ENTER;
                            end
                        end
                        else if (link_phase == gsp_pkg::PH_PERIODIC)
                        begin
                            link_phase = gsp_pkg::PH_IDLE;
                            idle_ticks = '0;
                        end
                        else
                        begin
                            link_phase = link_phase + 3'd1;
                        end
                    end
                end
                else
                begin
                    bit_pos = b + 1;
                end
            end
        end
        r.analog_locked = locked;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_phase = gsp_pkg::PH_INIT_POLL;
            byte_pos = 0;
            bit_pos = 0;
            second_half = 1'b0;
            gap_pending = 1'b0;
            locked = 1'b0;
            rx_shift = '0;
            idle_ticks = '0;
            poll_interval = gsp_pkg::INTERVAL_RST;
            polls_done = 0;
            for (int i = 0; i < gsp_pkg::PACKET_BYTES; i++)
                pad_store[i] = gsp_pkg::STORE_RESET;
            expected_pins.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pins.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result word with nothing pending");
                end
                else
                begin
                    want = expected_pins.pop_front();
                    check_field("select_n", want.select_n, select_n);
                    check_field("clock_pin", want.clock_pin, clock_pin);
                    check_field("command_pin", want.command_pin, command_pin);
                    check_field("keys", want.keys, keys);
                    check_field("stick_value", want.stick_value, stick_value);
                    check_field("analog_locked", want.analog_locked, analog_locked);
                    check_field("poll_done", want.poll_done, poll_done);
                end
            end
            if (in_valid && !in_stall)
            begin
                step_link(data_pin, key_read, keep_mask, stick_select, got);
                expected_pins.push_back(got);
            end
            if (cfg_valid && cfg_ready)
                poll_interval = cfg_data;
            pending = expected_pins.size();
        end
    end

endmodule

// ===== sim/tb_gamepad_serial_poller.sv =====
// testbench top for the gamepad serial poller: stimulus, receiver stalls and verdict
module tb_gamepad_serial_poller;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_ITEM   = 300;
    localparam logic [7:0] PAD_IDLE    = 8'hFF;
    localparam logic [7:0] PAD_READY   = 8'h5A;
    localparam logic [7:0] ID_DIGITAL  = 8'h41;
    localparam logic [7:0] ID_ANALOG_R = 8'h79;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        data_pin = 1'b1;
    logic        key_read = 1'b0;
    logic [15:0] keep_mask = '0;
    logic [1:0]  stick_select = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        select_n;
    logic        clock_pin;
    logic        command_pin;
    logic [15:0] keys;
    logic [7:0]  stick_value;
    logic        analog_locked;
    logic        poll_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // predicted link position, used to shape the pad's answer
    logic [2:0]  link_phase;
    int          byte_pos;
    int          bit_pos;
    logic        second_half;
    logic        gap_pending;
    logic        locked;
    int          polls_done;
    int          pending;
    int          fail_count;

    logic [7:0]  pad_reply [gsp_pkg::PACKET_BYTES];
    int          items_sent = 0;
    int          bad_checks_left = 0;
    logic        quiet = 1'b0;
    logic        hold_req = 1'b0;

    gamepad_serial_poller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_pin      (data_pin),
        .key_read      (key_read),
        .keep_mask     (keep_mask),
        .stick_select  (stick_select),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .select_n      (select_n),
        .clock_pin     (clock_pin),
        .command_pin   (command_pin),
        .keys          (keys),
        .stick_value   (stick_value),
        .analog_locked (analog_locked),
        .poll_done     (poll_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    gsp_link_checker link_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_pin      (data_pin),
        .key_read      (key_read),
        .keep_mask     (keep_mask),
        .stick_select  (stick_select),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .select_n      (select_n),
        .clock_pin     (clock_pin),
        .command_pin   (command_pin),
        .keys          (keys),
        .stick_value   (stick_value),
        .analog_locked (analog_locked),
        .poll_done     (poll_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .link_phase    (link_phase),
        .byte_pos      (byte_pos),
        .bit_pos       (bit_pos),
        .second_half   (second_half),
        .gap_pending   (gap_pending),
        .locked        (locked),
        .polls_done    (polls_done),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(15, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // receiver: random stall bursts plus one long hold-off on request
    initial
    begin
        int   stall_left;
        int   hold_left;
        logic hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
            end
        end
    end

    // called and returning at a falling edge; offers one tick word until taken
    task automatic offer_tick();
        logic [7:0] id;
        logic       in_poll;
        logic       din;
        int         gap;
        gap = (!quiet && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_poll = (link_phase == gsp_pkg::PH_INIT_POLL ||
                   link_phase == gsp_pkg::PH_CHECK_POLL ||
                   link_phase == gsp_pkg::PH_PERIODIC) && !gap_pending;

        // pad answer for a poll that starts with this tick
        if (in_poll && byte_pos == 0 && bit_pos == 0 && !second_half)
        begin
            if (link_phase == gsp_pkg::PH_CHECK_POLL && bad_checks_left > 0)
            begin
                bad_checks_left--;
                id = 8'($urandom_range(0, 255));
                if (id[7:4] == gsp_pkg::ID_LOCKED[7:4])
                    id[7:4] = ID_DIGITAL[7:4];
            end
            else if (link_phase == gsp_pkg::PH_CHECK_POLL)
            begin
                id = gsp_pkg::ID_ANALOG;
                if ($urandom_range(0, 3) == 0)
                    id[3:0] = 4'($urandom_range(0, 15));
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    id = gsp_pkg::ID_ANALOG;
                    2:       id = ID_DIGITAL;
                    3:       id = ID_ANALOG_R;
                    default: id = 8'($urandom_range(0, 255));
                endcase
            end
            for (int j = 0; j < gsp_pkg::PACKET_BYTES; j++)
            begin
                case ($urandom_range(0, 7))
                    0:       pad_reply[j] = 8'h00;
                    1:       pad_reply[j] = 8'hFF;
                    default: pad_reply[j] = 8'($urandom_range(0, 255));
                endcase
            end
            pad_reply[0] = PAD_IDLE;
            pad_reply[gsp_pkg::ID_BYTE] = id;
            pad_reply[2] = PAD_READY;
        end

        // sampling half of a poll bit carries the pad answer, with rare noise
        if (in_poll && second_half && byte_pos < gsp_pkg::PACKET_BYTES)
        begin
            din = pad_reply[byte_pos][bit_pos];
            if ($urandom_range(0, 39) == 0)
                din = ~din;
        end
        else
        begin
            din = 1'($urandom_range(0, 1));
        end
        data_pin <= din;

        if (items_sent < 24)
        begin
            key_read <= items_sent[2];
            stick_select <= items_sent[1:0];
            case (items_sent[4:3])
                2'd0: keep_mask <= 16'h0000;
                2'd1: keep_mask <= 16'hFFFF;
                2'd2: keep_mask <= 16'h5555;
                default: keep_mask <= 16'hAAAA;
            endcase
        end
        else
        begin
            // key read often lands on the tick that completes a key byte
            if (in_poll && second_half && bit_pos == 7 &&
                (byte_pos == gsp_pkg::KEY_LO || byte_pos == gsp_pkg::KEY_HI))
                key_read <= 1'($urandom_range(0, 1));
            else
                key_read <= ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 7))
                0:       keep_mask <= 16'h0000;
                1:       keep_mask <= 16'hFFFF;
                default: keep_mask <= 16'($urandom_range(0, 65535));
            endcase
            stick_select <= 2'($urandom_range(0, 3));
        end
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    // called and returning at a falling edge; block drained before the write
    task automatic set_interval(input logic [15:0] value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int lock_mark;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // init loop under the reset interval until the id check locks
        while (!locked)
        begin
            if (items_sent == HOLD_ITEM)
                hold_req = 1'b1;
            offer_tick();
        end

        // zero interval acts like one, the periodic poll follows at once
        quiet = 1'b1;
        set_interval(16'd0);
        lock_mark = polls_done;
        while (polls_done == lock_mark)
            offer_tick();
        quiet = 1'b0;

        // short interval: idle count up to the start of the next poll
        set_interval(16'($urandom_range(2, 8)));
        repeat (20) offer_tick();

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
